>>> hdl/skst_pkg.sv
package skst_pkg;

   // Table geometry. TABLE_SIZE must be a power of two: the slot is the low
   // bits of the hash.
   localparam int TABLE_SIZE  = 4096;
   localparam int SLOT_BITS   = $clog2(TABLE_SIZE);
   localparam int VALUE_BITS  = 32;
   localparam int TYPE_BITS   = 8;
   localparam int CHAR_BITS   = 7;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int WORD_BITS   = 32;
   localparam int INDEX_BITS  = 12;
   localparam int HASH_BITS   = 32;
   localparam int SHIFT_BITS  = 5;

   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_MISMATCH = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
      logic [TYPE_BITS-1:0]  tag;
   } entry_type;

   localparam int ENTRY_BITS = 1 + VALUE_BITS + TYPE_BITS;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [WORD_BITS-1:0] value;
      logic [TYPE_BITS-1:0] tag;
      logic [SLOT_BITS-1:0] slot;
   } op_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_BITS-1:0] addr;
      entry_type            data;
   } wr_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   found;
      logic                   write;
      entry_type              data;
   } result_type;

endpackage

>>> hdl/skst_ram.sv
module skst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/skst_hash.sv
module skst_hash (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [skst_pkg::CHAR_BITS-1:0]    key_char,
   input  logic                              key_last,
   output logic [skst_pkg::SLOT_BITS-1:0]    slot
);

   logic [skst_pkg::HASH_BITS-1:0] acc_ff;
   logic [skst_pkg::HASH_BITS-1:0] acc_in;
   logic [skst_pkg::HASH_BITS-1:0] hash_next;

   always_comb begin
      hash_next = acc_ff + (acc_ff << key_char[skst_pkg::SHIFT_BITS-1:0])
                  - skst_pkg::HASH_BITS'(key_char);
      acc_in = acc_ff;
      if (step) begin
         acc_in = key_last ? skst_pkg::HASH_BITS'(1) : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= skst_pkg::HASH_BITS'(1);
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign slot = hash_next[skst_pkg::SLOT_BITS-1:0];

endmodule

>>> hdl/skst_resolve.sv
module skst_resolve (
   input  logic                   clock,
   input  logic                   reset,
   input  skst_pkg::op_type       op,
   input  skst_pkg::entry_type    rd_entry,
   input  skst_pkg::wr_type       ram_wr,
   output skst_pkg::result_type   result
);

   // last word written to the RAM; covers a read that raced its write
   logic                           lw_valid_ff;
   logic [skst_pkg::SLOT_BITS-1:0] lw_addr_ff;
   skst_pkg::entry_type            lw_data_ff;
   skst_pkg::entry_type            entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (ram_wr.en) begin
         lw_valid_ff <= 1'b1;
      end
      if (ram_wr.en) begin
         lw_addr_ff <= ram_wr.addr;
         lw_data_ff <= ram_wr.data;
      end
   end

   always_comb begin
      entry = rd_entry;
      if (lw_valid_ff && (lw_addr_ff == op.slot)) begin
         entry = lw_data_ff;
      end

      result.status     = skst_pkg::STATUS_OK;
      result.found      = '0;
      result.write      = 1'b0;
      result.data.valid = 1'b1;
      result.data.value = skst_pkg::VALUE_BITS'($signed(op.value));
      result.data.tag   = op.tag;

      case (op.kind)
         skst_pkg::KIND_INSERT: begin
            if (entry.valid) begin
               result.status = skst_pkg::STATUS_OCCUPIED;
            end else begin
               result.write = 1'b1;
            end
         end
         skst_pkg::KIND_LOOKUP: begin
            if (entry.valid) begin
               result.found = skst_pkg::WORD_BITS'($signed(entry.value));
            end else begin
               result.status = skst_pkg::STATUS_EMPTY;
               result.found  = {skst_pkg::WORD_BITS{1'b1}};
            end
         end
         default: begin
            // typed lookup; kind 3 lands here as well
            if (!entry.valid) begin
               result.status = skst_pkg::STATUS_EMPTY;
            end else if (entry.tag != op.tag) begin
               result.status = skst_pkg::STATUS_MISMATCH;
            end else begin
               result.found = skst_pkg::WORD_BITS'($signed(entry.value));
            end
         end
      endcase
   end

endmodule

>>> hdl/streamed_key_symbol_table.sv
// Streamed-key symbol table: a direct-mapped hash table that takes its key
// one character per item and answers on the item that carries key_last.
// Each accepted item updates a 32-bit hash; the last character also reads
// the slot from a single-port-write, registered-read RAM that holds valid
// bit, value and type tag together, and stage 1 then decides and writes
// back an insert once the output register can take its result. A write
// that a following key's read just missed is forwarded from a last-write
// register, so keys may follow back to back: one item per cycle while the
// result side takes its items, and a result passes from stage 1 into the
// output register. Keys are not stored, so keys that share a slot share
// its entry. After reset a clearing pass writes every slot empty, and
// req_ready stays low while it runs.
module streamed_key_symbol_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [skst_pkg::CHAR_BITS-1:0]       req_key_char,
   input  logic                                 req_key_last,
   input  logic [skst_pkg::KIND_BITS-1:0]       req_kind,
   input  logic signed [skst_pkg::WORD_BITS-1:0] req_new_value,
   input  logic [skst_pkg::TYPE_BITS-1:0]       req_entry_type,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [skst_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic signed [skst_pkg::WORD_BITS-1:0] rsp_found_value,
   output logic [skst_pkg::INDEX_BITS-1:0]      rsp_slot_index
);

   logic                             clr_busy_ff;
   logic                             clr_busy_in;
   logic [skst_pkg::SLOT_BITS-1:0]   clr_addr_ff;
   logic [skst_pkg::SLOT_BITS-1:0]   clr_addr_in;

   logic                             p1_valid_ff;
   logic                             p1_valid_in;
   skst_pkg::op_type                 p1_op_ff;

   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic [skst_pkg::STATUS_BITS-1:0] out_status_ff;
   logic [skst_pkg::WORD_BITS-1:0]   out_found_ff;
   logic [skst_pkg::INDEX_BITS-1:0]  out_index_ff;

   logic                             advance;
   logic                             accept;
   logic                             complete;
   logic [skst_pkg::SLOT_BITS-1:0]   slot;
   skst_pkg::wr_type                 ram_wr;
   skst_pkg::entry_type              rd_entry;
   logic [skst_pkg::ENTRY_BITS-1:0]  rd_word;
   skst_pkg::result_type             result;

   // stage 1 may move only when the output register can take its item
   assign advance   = !p1_valid_ff || !out_valid_ff || rsp_ready;
   assign req_ready = !clr_busy_ff && advance;
   assign accept    = req_valid && req_ready;
   assign complete  = p1_valid_ff && advance;

   skst_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .key_char (req_key_char),
      .key_last (req_key_last),
      .slot     (slot)
   );

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == skst_pkg::SLOT_BITS'(skst_pkg::TABLE_SIZE - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      ram_wr.en   = 1'b0;
      ram_wr.addr = p1_op_ff.slot;
      ram_wr.data = result.data;
      if (clr_busy_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = clr_addr_ff;
         ram_wr.data = '0;
      end else if (complete && result.write) begin
         ram_wr.en = 1'b1;
      end

      p1_valid_in = p1_valid_ff;
      if (advance) begin
         p1_valid_in = accept && req_key_last;
      end

      out_valid_in = out_valid_ff;
      if (complete) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   skst_ram #(
      .WIDTH (skst_pkg::ENTRY_BITS),
      .DEPTH (skst_pkg::TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (accept && req_key_last),
      .rd_addr (slot),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   skst_resolve u_resolve (
      .clock    (clock),
      .reset    (reset),
      .op       (p1_op_ff),
      .rd_entry (rd_entry),
      .ram_wr   (ram_wr),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept && req_key_last) begin
         p1_op_ff.kind  <= req_kind;
         p1_op_ff.value <= req_new_value;
         p1_op_ff.tag   <= req_entry_type;
         p1_op_ff.slot  <= slot;
      end
      if (complete) begin
         out_status_ff <= result.status;
         out_found_ff  <= result.found;
         out_index_ff  <= skst_pkg::INDEX_BITS'(p1_op_ff.slot);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_found_value = out_found_ff;
   assign rsp_slot_index  = out_index_ff;

endmodule
